FILE: sv/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int FIELD_WIDTH = 16;
    localparam int COUNT_WIDTH = 5;

    typedef enum logic [0:0] {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t               req_type;
        logic [FIELD_WIDTH-1:0]  priority_req;
        logic [FIELD_WIDTH-1:0]  tag;
    } req_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0]  removed_tag;
        status_t                 status;
        logic [FIELD_WIDTH-1:0]  head_tag;
        logic                    head_valid;
        logic [COUNT_WIDTH-1:0]  entry_count;
    } rsp_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue: holds an entry and trades it with its neighbours.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PRIO_WIDTH = 16,
    parameter int TAG_WIDTH  = 16
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  spq_pkg::cell_ctrl_t     ctrl,
    input  wire [PRIO_WIDTH-1:0]    new_prio,
    input  wire [TAG_WIDTH-1:0]     new_tag,
    input  wire                     left_valid,
    input  wire                     left_lower,
    input  wire [PRIO_WIDTH-1:0]    left_prio,
    input  wire [TAG_WIDTH-1:0]     left_tag,
    input  wire                     right_valid,
    input  wire [PRIO_WIDTH-1:0]    right_prio,
    input  wire [TAG_WIDTH-1:0]     right_tag,
    output logic                    valid,
    output logic                    lower,
    output logic [PRIO_WIDTH-1:0]   prio,
    output logic [TAG_WIDTH-1:0]    tag,
    output logic [TAG_WIDTH-1:0]    tag_next
);
    import spq_pkg::*;

    logic                   valid_reg, valid_next;
    logic [PRIO_WIDTH-1:0]  prio_reg, prio_next;
    logic [TAG_WIDTH-1:0]   tag_reg;

    // empty slots count as lower so the new entry lands in the first free one
    assign lower = !valid_reg || ($signed(prio_reg) < $signed(new_prio));

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        tag_next   = tag_reg;
        if (ctrl.insert)
        begin
            valid_next = valid_reg | left_valid;
            if (lower && left_lower)
            begin
                prio_next = left_prio;
                tag_next  = left_tag;
            end
            else if (lower)
            begin
                prio_next = new_prio;
                tag_next  = new_tag;
            end
        end
        else if (ctrl.remove)
        begin
            valid_next = right_valid;
            prio_next  = right_prio;
            tag_next   = right_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        tag_reg  <= tag_next;
    end

    assign valid = valid_reg;
    assign prio  = prio_reg;
    assign tag   = tag_reg;

endmodule
`default_nettype wire

FILE: sv/sorted_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Shift-register priority queue, highest priority at the head, fifo on ties.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries insert and remove
//   requests; rsp channel (rsp_valid / rsp_stall / rsp) returns one result
//   per request with status, removed tag, head tag and entry count.
//   Every slot is a cell that compares its priority with the new one in
//   parallel and shifts in from its left or right neighbour, so the result
//   is in the output register in the cycle after acceptance, and one
//   request is taken per cycle while rsp drains.
//   When the receiver stalls, the result stays in the output register and
//   req_stall rises until it is taken; the next request is then accepted
//   in the cycle the result leaves.
//   An insert into a full queue and a remove from an empty queue leave the
//   queue unchanged and report ST_FULL / ST_EMPTY.
//   Reset clears every slot valid bit and the count; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
    parameter int DEPTH      = 16,
    parameter int PRIO_WIDTH = 16,
    parameter int TAG_WIDTH  = 16
) (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             req_valid,
    output logic            req_stall,
    input  spq_pkg::req_t   req,
    output logic            rsp_valid,
    input  wire             rsp_stall,
    output spq_pkg::rsp_t   rsp
);
    import spq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic                   vld    [DEPTH];
    logic                   lwr    [DEPTH];
    logic [PRIO_WIDTH-1:0]  prio   [DEPTH];
    logic [TAG_WIDTH-1:0]   tg     [DEPTH];
    logic [TAG_WIDTH-1:0]   tg_nxt [DEPTH];
    logic [DEPTH-1:0]       vld_vec;

    logic                   accept;
    logic                   full, empty;
    cell_ctrl_t             ctrl;
    logic [PRIO_WIDTH-1:0]  new_prio;
    logic [TAG_WIDTH-1:0]   new_tag;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg, rsp_next;

    assign req_stall = rsp_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = vld[DEPTH-1];
    assign empty     = !vld[0];

    assign new_prio = PRIO_WIDTH'({{PRIO_WIDTH{1'b0}}, req.priority_req});
    assign new_tag  = TAG_WIDTH'({{TAG_WIDTH{1'b0}}, req.tag});

    always_comb
    begin
        ctrl.insert = accept && (req.req_type == REQ_INSERT) && !full;
        ctrl.remove = accept && (req.req_type == REQ_REMOVE) && !empty;
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                   l_valid, l_lower, r_valid;
            logic [PRIO_WIDTH-1:0]  l_prio, r_prio;
            logic [TAG_WIDTH-1:0]   l_tag, r_tag;

            if (g == 0)
            begin : g_first
                assign l_valid = 1'b1;
                assign l_lower = 1'b0;
                assign l_prio  = '0;
                assign l_tag   = '0;
            end
            else
            begin : g_mid_l
                assign l_valid = vld[g-1];
                assign l_lower = lwr[g-1];
                assign l_prio  = prio[g-1];
                assign l_tag   = tg[g-1];
            end

            if (g == DEPTH - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_prio  = '0;
                assign r_tag   = '0;
            end
            else
            begin : g_mid_r
                assign r_valid = vld[g+1];
                assign r_prio  = prio[g+1];
                assign r_tag   = tg[g+1];
            end

            spq_cell #(
                .PRIO_WIDTH (PRIO_WIDTH),
                .TAG_WIDTH  (TAG_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_prio    (new_prio),
                .new_tag     (new_tag),
                .left_valid  (l_valid),
                .left_lower  (l_lower),
                .left_prio   (l_prio),
                .left_tag    (l_tag),
                .right_valid (r_valid),
                .right_prio  (r_prio),
                .right_tag   (r_tag),
                .valid       (vld[g]),
                .lower       (lwr[g]),
                .prio        (prio[g]),
                .tag         (tg[g]),
                .tag_next    (tg_nxt[g])
            );

            assign vld_vec[g] = vld[g];
        end
    endgenerate

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.insert)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (ctrl.remove)
        begin
            cnt_next = cnt_reg - CW'(1);
        end

        rsp_next.removed_tag = '0;
        rsp_next.status      = ST_OK;
        if (req.req_type == REQ_INSERT)
        begin
            if (full)
            begin
                rsp_next.status = ST_FULL;
            end
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.removed_tag = FIELD_WIDTH'({{FIELD_WIDTH{1'b0}}, tg[0]});
        end

        // head after the step: cell 0 is valid whenever the count stays non-zero
        rsp_next.head_valid = (cnt_next != '0);
        rsp_next.head_tag   = '0;
        if (cnt_next != '0)
        begin
            rsp_next.head_tag = FIELD_WIDTH'({{FIELD_WIDTH{1'b0}}, tg_nxt[0]});
        end
        rsp_next.entry_count = COUNT_WIDTH'({{COUNT_WIDTH{1'b0}}, cnt_next});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // valid slots form a prefix from slot 0
    a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((vld_vec + DEPTH'(1)) & vld_vec) == '0)
        else $error("slot valid bits are not a prefix");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(vld_vec) == int'(cnt_reg))
        else $error("entry count disagrees with slot valid bits");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request gave no result");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == REQ_INSERT) && (cnt_reg != CW'(DEPTH)))
            |=> (rsp_reg.status == ST_OK))
        else $error("insert dropped while queue had room");

endmodule
`default_nettype wire
